// ===== rtl/chacha20_keystream_random_generator_core_macros.svh =====
// Assertion macros used by the checker of the random generator.
`ifndef CHACHA20_KEYSTREAM_RANDOM_GENERATOR_CORE_MACROS_SVH
`define CHACHA20_KEYSTREAM_RANDOM_GENERATOR_CORE_MACROS_SVH

// Checked only outside reset.
`define CC20RNG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CC20RNG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/cc20rng_pkg.sv =====
`default_nettype none

package cc20rng_pkg;

   localparam int DOUBLE_ROUNDS = 10;
   localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

   localparam int KEY_WORDS   = 8;
   localparam int NONCE_WORDS = 3;
   localparam int BLOCK_WORDS = 16;
   localparam int BLOCK_BYTES = 64;

   localparam int ROT_1 = 16;
   localparam int ROT_2 = 12;
   localparam int ROT_3 = 8;
   localparam int ROT_4 = 7;

   typedef logic [31:0] word_type;

   localparam word_type SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                      32'h79622d32, 32'h6b206574};

   typedef enum logic [1:0] {
      CMD_READ = 2'd0,
      CMD_MIX  = 2'd1,
      CMD_SEED = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL
   } state_type;

   localparam logic [2:0] CSR_KEY_0_1   = 3'd0;
   localparam logic [2:0] CSR_KEY_2_3   = 3'd1;
   localparam logic [2:0] CSR_KEY_4_5   = 3'd2;
   localparam logic [2:0] CSR_KEY_6_7   = 3'd3;
   localparam logic [2:0] CSR_NONCE_0_1 = 3'd4;
   localparam logic [2:0] CSR_NONCE_2   = 3'd5;

   // Rotation of one quarter-round step, selected by the step number.
   function automatic word_type rotl_step(word_type w, logic [1:0] k);
      word_type r;
      case (k)
         2'd0:    r = (w << ROT_1) | (w >> (32 - ROT_1));
         2'd1:    r = (w << ROT_2) | (w >> (32 - ROT_2));
         2'd2:    r = (w << ROT_3) | (w >> (32 - ROT_3));
         default: r = (w << ROT_4) | (w >> (32 - ROT_4));
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/chacha20_keystream_random_generator_core.sv =====
// ChaCha20 random byte generator. Each accepted read command returns one keystream
// byte; a mix command XORs a word into the key and, when marked last, rekeys the
// generator from one block of its own; a seed command loads the configured key and
// nonce. A read served from the 64-byte buffer is answered in the next cycle. A read that
// finds the buffer empty, and a rekey, compute a block of DOUBLE_ROUNDS double rounds
// (20 rounds) in the load, round and final states: one quarter-round step of all four
// lanes per cycle, in a single shared step unit. The block does not take input while a
// block is computed or while a result is held stalled.
`default_nettype none

module chacha20_keystream_random_generator_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  cc20rng_pkg::word_type req_entropy_word,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_random_byte,
   input  logic                  csr_wen,
   input  logic [2:0]            csr_index,
   input  logic [63:0]           csr_wdata
);
   import cc20rng_pkg::*;

   state_type        state_ff, state_in;
   logic [63:0]      seed_ff [5];
   word_type         seed_n2_ff;
   word_type         key_ff [KEY_WORDS];
   word_type         key_in [KEY_WORDS];
   word_type         nonce_ff [NONCE_WORDS];
   word_type         nonce_in [NONCE_WORDS];
   word_type         counter_ff, counter_in;
   logic [6:0]       pos_ff, pos_in;
   logic [2:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   word_type         x_ff [BLOCK_WORDS];
   word_type         x_in [BLOCK_WORDS];
   word_type         ks_ff [BLOCK_WORDS];
   word_type         ks_in [BLOCK_WORDS];
   logic [2:0]       step_ff, step_in;
   logic [DR_W-1:0]  dr_ff, dr_in;
   logic             rekey_ff, rekey_in;

   logic             accept;
   logic             diag;
   logic [1:0]       k;
   word_type         va [4];
   word_type         vb [4];
   word_type         vc [4];
   word_type         vd [4];
   word_type         na [4];
   word_type         nb [4];
   word_type         nc [4];
   word_type         nd [4];
   word_type         step_x [BLOCK_WORDS];
   word_type         init_w [BLOCK_WORDS];
   word_type         sum_w [BLOCK_WORDS];
   word_type         rd_word;
   logic [7:0]       rd_byte;

   assign req_stall       = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept          = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_byte = rsp_byte_ff;

   assign rd_word = ks_ff[pos_ff[5:2]];
   assign rd_byte = 8'(rd_word >> {pos_ff[1:0], 3'b000});

   // Block input words and the final feed-forward sum.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init_w[i] = SIGMA[i];
      end
      for (int i = 0; i < KEY_WORDS; i++) begin
         init_w[4 + i] = key_ff[i];
      end
      init_w[12] = counter_ff;
      for (int i = 0; i < NONCE_WORDS; i++) begin
         init_w[13 + i] = nonce_ff[i];
      end
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         sum_w[i] = x_ff[i] + init_w[i];
      end
   end

   // Shared step unit: one add, XOR and rotate in each of the four lanes. Even
   // steps update rows a and d, odd steps rows c and b; diagonal rounds route the
   // rows through the lanes with fixed offsets.
   always_comb begin
      diag = step_ff[2];
      k    = step_ff[1:0];
      for (int i = 0; i < 4; i++) begin
         va[i] = x_ff[i];
         vb[i] = diag ? x_ff[4 + ((i + 1) % 4)]  : x_ff[4 + i];
         vc[i] = diag ? x_ff[8 + ((i + 2) % 4)]  : x_ff[8 + i];
         vd[i] = diag ? x_ff[12 + ((i + 3) % 4)] : x_ff[12 + i];
         if (!k[0]) begin
            na[i] = va[i] + vb[i];
            nd[i] = rotl_step(vd[i] ^ na[i], k);
            nb[i] = vb[i];
            nc[i] = vc[i];
         end else begin
            nc[i] = vc[i] + vd[i];
            nb[i] = rotl_step(vb[i] ^ nc[i], k);
            na[i] = va[i];
            nd[i] = vd[i];
         end
      end
      for (int j = 0; j < 4; j++) begin
         step_x[j]      = na[j];
         step_x[4 + j]  = diag ? nb[(j + 3) % 4] : nb[j];
         step_x[8 + j]  = diag ? nc[(j + 2) % 4] : nc[j];
         step_x[12 + j] = diag ? nd[(j + 1) % 4] : nd[j];
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      nonce_in     = nonce_ff;
      counter_in   = counter_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      x_in         = x_ff;
      ks_in        = ks_ff;
      step_in      = step_ff;
      dr_in        = dr_ff;
      rekey_in     = rekey_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_cmd))
                  CMD_READ: begin
                     if (pos_ff[6]) begin
                        rekey_in = 1'b0;
                        state_in = ST_LOAD;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_byte_in  = rd_byte;
                        pos_in       = pos_ff + 7'd1;
                     end
                  end
                  CMD_MIX: begin
                     key_in[idx_ff] = key_ff[idx_ff] ^ req_entropy_word;
                     idx_in         = idx_ff + 3'd1;
                     if (req_last) begin
                        counter_in = counter_ff + 32'd1;
                        rekey_in   = 1'b1;
                        state_in   = ST_LOAD;
                     end
                  end
                  CMD_SEED: begin
                     for (int i = 0; i < 4; i++) begin
                        key_in[2 * i]     = seed_ff[i][31:0];
                        key_in[2 * i + 1] = seed_ff[i][63:32];
                     end
                     nonce_in[0] = seed_ff[4][31:0];
                     nonce_in[1] = seed_ff[4][63:32];
                     nonce_in[2] = seed_n2_ff;
                     counter_in  = '0;
                     pos_in      = 7'(BLOCK_BYTES);
                     idx_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            x_in     = init_w;
            step_in  = '0;
            dr_in    = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            x_in    = step_x;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               dr_in = dr_ff + DR_W'(1);
               if (dr_ff == DR_W'(DOUBLE_ROUNDS - 1)) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            state_in = ST_IDLE;
            if (rekey_ff) begin
               for (int i = 0; i < KEY_WORDS; i++) begin
                  key_in[i] = sum_w[i];
               end
               for (int i = 0; i < NONCE_WORDS; i++) begin
                  nonce_in[i] = sum_w[KEY_WORDS + i];
               end
               pos_in = 7'(BLOCK_BYTES);
               idx_in = '0;
            end else begin
               ks_in        = sum_w;
               counter_in   = counter_ff + 32'd1;
               pos_in       = 7'd1;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = sum_w[0][7:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '{default: '0};
         nonce_ff     <= '{default: '0};
         counter_ff   <= '0;
         pos_ff       <= 7'(BLOCK_BYTES);
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         nonce_ff     <= nonce_in;
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      ks_ff       <= ks_in;
      step_ff     <= step_in;
      dr_ff       <= dr_in;
      rekey_ff    <= rekey_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= '{default: '0};
         seed_n2_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_KEY_0_1:   seed_ff[0] <= csr_wdata;
            CSR_KEY_2_3:   seed_ff[1] <= csr_wdata;
            CSR_KEY_4_5:   seed_ff[2] <= csr_wdata;
            CSR_KEY_6_7:   seed_ff[3] <= csr_wdata;
            CSR_NONCE_0_1: seed_ff[4] <= csr_wdata;
            CSR_NONCE_2:   seed_n2_ff <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cc20rng_checker.sv =====
`default_nettype none
`include "chacha20_keystream_random_generator_core_macros.svh"

module cc20rng_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_cmd,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_random_byte
);
   import cc20rng_pkg::*;

   logic take;
   logic held;

   assign take = req_valid && !req_stall;
   assign held = rsp_valid && rsp_stall;

   // A stalled word holds its value.
   `CC20RNG_ASSERT(a_rsp_hold, held |=> rsp_valid && $stable(rsp_random_byte), "word changed")

   // Reset leaves no word pending.
   `CC20RNG_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "word pending after reset")

   // Mix and seed commands never produce a word.
   `CC20RNG_ASSERT(a_no_word, take && req_cmd != CMD_READ |=> !rsp_valid, "no word expected")

   // No command is taken while a word waits stalled.
   `CC20RNG_ASSERT(a_stall_through, held |-> req_stall, "command taken while word stalled")

endmodule

bind chacha20_keystream_random_generator_core cc20rng_checker u_checker (.*);

`default_nettype wire
